FILE: rtl/core/rie_pkg.sv
// ----------------------------------------------------------------------------
// rie_pkg: shared types and constants for the instruction execute block
// Operation codes, fault codes, config register indexes, and the command and
// status structs that join the controller with the datapath.
// ----------------------------------------------------------------------------
package rie_pkg;

   localparam int MemWordsDefault = 65536;
   localparam int RegCountDefault = 32;

   typedef enum logic [5:0] {
      OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BEQ, OP_BNE, OP_BLT, OP_BGE,
      OP_BLTU, OP_BGEU, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH,
      OP_SW, OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI, OP_SLLI,
      OP_SRLI, OP_SRAI, OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR,
      OP_SRL, OP_SRA, OP_OR, OP_AND, OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU,
      OP_DIV, OP_DIVU, OP_REM, OP_REMU, OP_ROT, OP_IN, OP_OUT
   } op_type;

   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_BAD_OP  = 2'd1;
   localparam logic [1:0] FAULT_CONTEST = 2'd2;

   localparam logic CSR_PC_STEP      = 1'b0;
   localparam logic CSR_CONTEST_MODE = 1'b1;

   localparam logic [7:0] CONTEST_BYTE = 8'haa;

   // controller -> datapath commands
   typedef struct packed {
      logic capture;    // latch request and read registers
      logic mem_rd;     // issue memory read
      logic mul_go;     // register multiply product
      logic div_start;  // load divider
      logic div_step;   // one divider iteration
      logic finish;     // compute result and commit state
   } dp_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic is_load;
      logic is_mul;
      logic is_div;
      logic div_done;
   } dp_stat_type;

endpackage

FILE: rtl/core/rie_chan_if.sv
// ----------------------------------------------------------------------------
// rie_chan_if: valid/ready channel
// Generic payload channel with source and sink modports.
// ----------------------------------------------------------------------------
interface rie_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/risc_instruction_execute.sv
// ----------------------------------------------------------------------------
// risc_instruction_execute: integer instruction execute block
// Runs one decoded instruction per request against registers, PC and memory.
//
//  channel | dir | payload
//  req     | in  | op, dest_reg, src_a, src_b, immediate, in_byte
//  rsp     | out | next_pc, reg_write, write_index, write_value, out_valid,
//          |     | out_byte, fault
//  csr     | in  | index (0 pc_step, 1 contest_mode), data
//
// Sequence: capture, decode, then commit for ALU, branch and store; load and
// multiply add a memory read or product register step; divide iterates one radix-2 step a cycle.
// Reset clears registers, PC and control; data memory is not cleared.
// A new request is taken while the previous response waits; a stalled rsp side
// holds the sequencer in its commit step.
// ----------------------------------------------------------------------------
module risc_instruction_execute
   import rie_pkg::*;
#(
   parameter int MEM_WORDS = MemWordsDefault,
   parameter int REG_COUNT = RegCountDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [5:0]  req_op,
   input  logic [4:0]  req_dest_reg,
   input  logic [4:0]  req_src_a,
   input  logic [4:0]  req_src_b,
   input  logic [31:0] req_immediate,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_reg_write,
   output logic [4:0]  rsp_write_index,
   output logic [31:0] rsp_write_value,
   output logic        rsp_out_valid,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_fault,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [2:0]  csr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   rie_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd
   );

   rie_dp #(.MEM_WORDS(MEM_WORDS), .REG_COUNT(REG_COUNT)) u_dp (
      .clock, .reset, .cmd, .stat,
      .req_op, .req_dest_reg, .req_src_a, .req_src_b, .req_immediate, .req_in_byte,
      .csr_we(csr_valid), .csr_idx(csr_index), .csr_data(csr_data),
      .csr_contest(csr_data[0]),
      .rsp_next_pc, .rsp_reg_write, .rsp_write_index, .rsp_write_value,
      .rsp_out_valid, .rsp_out_byte, .rsp_fault
   );

endmodule

FILE: rtl/core/rie_ctrl.sv
// ----------------------------------------------------------------------------
// rie_ctrl: execute sequencer
// Walks each instruction through capture, optional memory read, multiply or
// divide iterations, commit and result handoff.
// ----------------------------------------------------------------------------
module rie_ctrl
   import rie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_MEM, ST_MUL, ST_DIV, ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // a new item may enter while the previous result still waits
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_load) begin
               cmd.mem_rd = 1'b1;
               state_in   = ST_MEM;
            end else if (stat.is_mul) begin
               cmd.mul_go = 1'b1;
               state_in   = ST_MUL;
            end else if (stat.is_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MEM, ST_MUL: state_in = ST_FINISH;
         ST_DIV: begin
            if (stat.div_done) state_in = ST_FINISH;
            else cmd.div_step = 1'b1;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready)) else $error("result overwritten");
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid) else $error("finish without result");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd)) else $error("multiple commands");

endmodule

FILE: rtl/core/rie_dp.sv
// ----------------------------------------------------------------------------
// rie_dp: execute datapath
// Register file, PC, data memory, ALU, multiplier, radix-2 divider and the
// result register.
// ----------------------------------------------------------------------------
module rie_dp
   import rie_pkg::*;
#(
   parameter int MEM_WORDS = MemWordsDefault,
   parameter int REG_COUNT = RegCountDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic [5:0]  req_op,
   input  logic [4:0]  req_dest_reg,
   input  logic [4:0]  req_src_a,
   input  logic [4:0]  req_src_b,
   input  logic [31:0] req_immediate,
   input  logic [7:0]  req_in_byte,
   input  logic        csr_we,
   input  logic [0:0]  csr_idx,
   input  logic [2:0]  csr_data,
   input  logic        csr_contest,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_reg_write,
   output logic [4:0]  rsp_write_index,
   output logic [31:0] rsp_write_value,
   output logic        rsp_out_valid,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_fault
);

   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int RW = $clog2(REG_COUNT);

   logic [31:0]    rf_ff [REG_COUNT];
   logic [31:0]    mem_ff [MEM_WORDS];
   logic [31:0]    pc_ff, pc_in;
   logic [2:0]     step_ff;
   logic           pend_ff, pend_in;

   logic [5:0]     op_ff;
   logic [RW-1:0]  rd_ff;
   logic [31:0]    imm_ff, a_ff, b_ff, d_ff;
   logic [7:0]     ib_ff;
   logic [31:0]    rdata_ff;
   logic [63:0]    prod_ff;

   // divider state
   logic [31:0]    dq_ff, dr_ff, dd_ff;
   logic [5:0]     dcnt_ff;
   logic           dneg_q_ff, dneg_r_ff;

   logic [31:0]    ea;
   assign ea = a_ff + imm_ff;

   always_comb begin
      stat.is_load  = (op_ff >= OP_LB) && (op_ff <= OP_LHU);
      stat.is_mul   = (op_ff >= OP_MUL) && (op_ff <= OP_MULHU);
      stat.is_div   = (op_ff >= OP_DIV) && (op_ff <= OP_REMU);
      stat.div_done = dcnt_ff[5];
   end

   // multiplier operands extended by sign as the op needs
   logic signed [32:0] ma, mb;
   always_comb begin
      ma = {(op_ff == OP_MULH || op_ff == OP_MULHSU) & a_ff[31], a_ff};
      mb = {(op_ff == OP_MULH) & b_ff[31], b_ff};
   end

   // divider magnitudes
   logic        sdiv;
   logic [31:0] ua, ub;
   logic [32:0] trial;
   always_comb begin
      sdiv  = (op_ff == OP_DIV) || (op_ff == OP_REM);
      ua    = (sdiv && a_ff[31]) ? (32'd0 - a_ff) : a_ff;
      ub    = (sdiv && b_ff[31]) ? (32'd0 - b_ff) : b_ff;
      trial = {dr_ff, dq_ff[31]} - {1'b0, dd_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_op;
         rd_ff  <= req_dest_reg[RW-1:0];
         imm_ff <= req_immediate;
         ib_ff  <= req_in_byte;
         a_ff   <= rf_ff[req_src_a[RW-1:0]];
         b_ff   <= rf_ff[req_src_b[RW-1:0]];
         d_ff   <= rf_ff[req_dest_reg[RW-1:0]];
      end
      if (cmd.mem_rd) rdata_ff <= mem_ff[ea[AW-1:0]];
      if (cmd.mul_go) prod_ff <= 64'(ma * mb);
      if (cmd.div_start) begin
         dq_ff     <= ua;
         dr_ff     <= '0;
         dd_ff     <= ub;
         dcnt_ff   <= 6'd0;
         dneg_q_ff <= sdiv && (a_ff[31] != b_ff[31]) && (b_ff != 32'd0);
         dneg_r_ff <= sdiv && a_ff[31];
      end else if (cmd.div_step) begin
         if (!trial[32]) dr_ff <= trial[31:0];
         else dr_ff <= {dr_ff[30:0], dq_ff[31]};
         dq_ff   <= {dq_ff[30:0], ~trial[32]};
         dcnt_ff <= dcnt_ff + 6'd1;
      end
   end

   // result
   logic [31:0] seq, br_tgt, val, npc, quo, rem, sh_b;
   logic        wr, ov, lts, ltu, ltsi, ltui;
   logic [7:0]  ob;
   logic [1:0]  flt;
   always_comb begin
      seq    = pc_ff + 32'(step_ff);
      br_tgt = pc_ff + imm_ff;
      lts    = $signed(a_ff) < $signed(b_ff);
      ltu    = a_ff < b_ff;
      ltsi   = $signed(a_ff) < $signed(imm_ff);
      ltui   = a_ff < imm_ff;
      quo    = dneg_q_ff ? (32'd0 - dq_ff) : dq_ff;
      rem    = dneg_r_ff ? (32'd0 - dr_ff) : dr_ff;
      sh_b   = b_ff;
      npc    = seq;
      val    = '0;
      wr     = 1'b0;
      ov     = 1'b0;
      ob     = '0;
      flt    = FAULT_NONE;
      pend_in = pend_ff;
      case (op_ff)
         OP_LUI:   begin wr = 1'b1; val = imm_ff; end
         OP_AUIPC: begin wr = 1'b1; val = br_tgt; end
         OP_JAL:   begin wr = 1'b1; val = seq; npc = br_tgt; end
         OP_JALR:  begin wr = 1'b1; val = seq; npc = ea; end
         OP_BEQ:   if (a_ff == b_ff) npc = br_tgt;
         OP_BNE:   if (a_ff != b_ff) npc = br_tgt;
         OP_BLT:   if (lts) npc = br_tgt;
         OP_BGE:   if (!lts) npc = br_tgt;
         OP_BLTU:  if (ltu) npc = br_tgt;
         OP_BGEU:  if (!ltu) npc = br_tgt;
         OP_LB:    begin wr = 1'b1; val = {{24{rdata_ff[7]}}, rdata_ff[7:0]}; end
         OP_LH:    begin wr = 1'b1; val = {{16{rdata_ff[15]}}, rdata_ff[15:0]}; end
         OP_LW:    begin wr = 1'b1; val = rdata_ff; end
         OP_LBU:   begin wr = 1'b1; val = {24'd0, rdata_ff[7:0]}; end
         OP_LHU:   begin wr = 1'b1; val = {16'd0, rdata_ff[15:0]}; end
         OP_SB, OP_SH, OP_SW: ;
         OP_ADDI:  begin wr = 1'b1; val = ea; end
         OP_SLTI:  begin wr = 1'b1; val = {31'd0, ltsi}; end
         OP_SLTIU: begin wr = 1'b1; val = {31'd0, ltui}; end
         OP_XORI:  begin wr = 1'b1; val = a_ff ^ imm_ff; end
         OP_ORI:   begin wr = 1'b1; val = a_ff | imm_ff; end
         OP_ANDI:  begin wr = 1'b1; val = a_ff & imm_ff; end
         OP_SLLI:  begin wr = 1'b1; val = a_ff << imm_ff[4:0]; end
         OP_SRLI:  begin wr = 1'b1; val = a_ff >> imm_ff[4:0]; end
         OP_SRAI:  begin wr = 1'b1; val = 32'($signed(a_ff) >>> imm_ff[4:0]); end
         OP_ADD:   begin wr = 1'b1; val = a_ff + b_ff; end
         OP_SUB:   begin wr = 1'b1; val = a_ff - b_ff; end
         OP_SLL:   begin wr = 1'b1; val = a_ff << sh_b[4:0]; end
         OP_SLT:   begin wr = 1'b1; val = {31'd0, lts}; end
         OP_SLTU:  begin wr = 1'b1; val = {31'd0, ltu}; end
         OP_XOR:   begin wr = 1'b1; val = a_ff ^ b_ff; end
         OP_SRL:   begin wr = 1'b1; val = a_ff >> sh_b[4:0]; end
         OP_SRA:   begin wr = 1'b1; val = 32'($signed(a_ff) >>> sh_b[4:0]); end
         OP_OR:    begin wr = 1'b1; val = a_ff | b_ff; end
         OP_AND:   begin wr = 1'b1; val = a_ff & b_ff; end
         OP_MUL:   begin wr = 1'b1; val = prod_ff[31:0]; end
         OP_MULH, OP_MULHSU, OP_MULHU: begin wr = 1'b1; val = prod_ff[63:32]; end
         // zero divisor: unsigned restoring gives all-ones quotient, remainder = a;
         // overflow case comes out right from magnitude arithmetic
         OP_DIV, OP_DIVU: begin wr = 1'b1; val = quo; end
         OP_REM, OP_REMU: begin wr = 1'b1; val = rem; end
         OP_ROT:   begin wr = 1'b1; val = {a_ff[7:0], a_ff[15:8], a_ff[23:16], a_ff[31:24]}; end
         OP_IN: begin
            if (pend_ff) flt = FAULT_CONTEST;
            else begin wr = 1'b1; val = {d_ff[31:8], ib_ff}; end
         end
         OP_OUT: begin
            if (pend_ff && a_ff[7:0] == CONTEST_BYTE) pend_in = 1'b0;
            else begin ov = 1'b1; ob = a_ff[7:0]; end
         end
         default: begin flt = FAULT_BAD_OP; npc = pc_ff; end
      endcase
      if (rd_ff == '0) begin
         wr  = 1'b0;
         val = '0;
      end
      pc_in = npc;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (op_ff == OP_SB) mem_ff[ea[AW-1:0]] <= {24'd0, b_ff[7:0]};
         else if (op_ff == OP_SH) mem_ff[ea[AW-1:0]] <= {16'd0, b_ff[15:0]};
         else if (op_ff == OP_SW) mem_ff[ea[AW-1:0]] <= b_ff;
         rsp_next_pc     <= npc;
         rsp_reg_write   <= wr;
         rsp_write_index <= wr ? 5'(rd_ff) : 5'd0;
         rsp_write_value <= val;
         rsp_out_valid   <= ov;
         rsp_out_byte    <= ob;
         rsp_fault       <= flt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) rf_ff[i] <= '0;
         pc_ff   <= '0;
         step_ff <= 3'd4;
         pend_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            if (wr) rf_ff[rd_ff] <= val;
            pc_ff <= pc_in;
         end
         if (csr_we && csr_idx == CSR_PC_STEP) step_ff <= csr_data;
         if (csr_we && csr_idx == CSR_CONTEST_MODE) pend_ff <= csr_contest;
         else if (cmd.finish) pend_ff <= pend_in;
      end
   end

   a_x0_zero: assert property (@(posedge clock) disable iff (reset)
      rf_ff[0] == 32'd0) else $error("x0 written");
   a_pc_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.finish && !$past(reset) |=> $stable(pc_ff)) else $error("pc moved");
   a_bad_op: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && flt == FAULT_BAD_OP |-> !wr && npc == pc_ff) else $error("bad op");

endmodule

FILE: tb/risc_instruction_execute_test.sv
// ----------------------------------------------------------------------------
// risc_instruction_execute_test: self-checking bench for the execute block
// Drives decoded instructions through valid/ready channels, predicts every
// response from a local copy of registers, PC, memory and contest state, and
// compares each response field by field. Runs several pc_step/contest_mode
// settings with varied sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module risc_instruction_execute_test;
   import rie_pkg::*;

   typedef struct packed {
      logic [5:0]  op;
      logic [4:0]  dest_reg;
      logic [4:0]  src_a;
      logic [4:0]  src_b;
      logic [31:0] immediate;
      logic [7:0]  in_byte;
   } instr_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        reg_write;
      logic [4:0]  write_index;
      logic [31:0] write_value;
      logic        out_valid;
      logic [7:0]  out_byte;
      logic [1:0]  fault;
   } result_type;

   typedef struct packed {
      logic [0:0] index;
      logic [2:0] data;
   } csr_type;

   class exec_scoreboard;
      logic [31:0] regs [32];
      logic [31:0] mem [int unsigned];
      int unsigned stored_words[$];
      logic [31:0] pc;
      logic [2:0]  step;
      logic        pending;
      result_type  pending_results[$];
      int          errors;

      function new();
         foreach (regs[i]) regs[i] = '0;
         pc = '0;
         step = 3'd4;
         pending = 1'b0;
         errors = 0;
      endfunction

      function void configure(logic [0:0] index, logic [2:0] data);
         if (index == CSR_PC_STEP) step = data;
         else pending = data[0];
      endfunction

      function void note(instr_type r);
         logic [31:0] a, b, imm, seq, npc, val, ea;
         logic [63:0] prod;
         logic [7:0]  ob;
         logic        wr, ov;
         logic [1:0]  flt;
         int unsigned idx;
         result_type  res;
         a = regs[r.src_a];
         b = regs[r.src_b];
         imm = r.immediate;
         seq = pc + {29'd0, step};
         npc = seq;
         val = '0;
         ob = '0;
         wr = 1'b0;
         ov = 1'b0;
         flt = FAULT_NONE;
         ea = a + imm;
         idx = ea % MemWordsDefault;
         case (r.op)
            OP_LUI:    begin wr = 1; val = imm; end
            OP_AUIPC:  begin wr = 1; val = pc + imm; end
            OP_JAL:    begin wr = 1; val = seq; npc = pc + imm; end
            OP_JALR:   begin wr = 1; val = seq; npc = a + imm; end
            OP_BEQ:    if (a == b) npc = pc + imm;
            OP_BNE:    if (a != b) npc = pc + imm;
            OP_BLT:    if ($signed(a) < $signed(b)) npc = pc + imm;
            OP_BGE:    if ($signed(a) >= $signed(b)) npc = pc + imm;
            OP_BLTU:   if (a < b) npc = pc + imm;
            OP_BGEU:   if (a >= b) npc = pc + imm;
            OP_LB:     begin wr = 1; val = {{24{mem[idx][7]}}, mem[idx][7:0]}; end
            OP_LH:     begin wr = 1; val = {{16{mem[idx][15]}}, mem[idx][15:0]}; end
            OP_LW:     begin wr = 1; val = mem[idx]; end
            OP_LBU:    begin wr = 1; val = {24'd0, mem[idx][7:0]}; end
            OP_LHU:    begin wr = 1; val = {16'd0, mem[idx][15:0]}; end
            OP_SB:     begin mem[idx] = {24'd0, b[7:0]}; stored_words.push_back(idx); end
            OP_SH:     begin mem[idx] = {16'd0, b[15:0]}; stored_words.push_back(idx); end
            OP_SW:     begin mem[idx] = b; stored_words.push_back(idx); end
            OP_ADDI:   begin wr = 1; val = a + imm; end
            OP_SLTI:   begin wr = 1; val = ($signed(a) < $signed(imm)) ? 1 : 0; end
            OP_SLTIU:  begin wr = 1; val = (a < imm) ? 1 : 0; end
            OP_XORI:   begin wr = 1; val = a ^ imm; end
            OP_ORI:    begin wr = 1; val = a | imm; end
            OP_ANDI:   begin wr = 1; val = a & imm; end
            OP_SLLI:   begin wr = 1; val = a << imm[4:0]; end
            OP_SRLI:   begin wr = 1; val = a >> imm[4:0]; end
            OP_SRAI:   begin wr = 1; val = $signed(a) >>> imm[4:0]; end
            OP_ADD:    begin wr = 1; val = a + b; end
            OP_SUB:    begin wr = 1; val = a - b; end
            OP_SLL:    begin wr = 1; val = a << b[4:0]; end
            OP_SLT:    begin wr = 1; val = ($signed(a) < $signed(b)) ? 1 : 0; end
            OP_SLTU:   begin wr = 1; val = (a < b) ? 1 : 0; end
            OP_XOR:    begin wr = 1; val = a ^ b; end
            OP_SRL:    begin wr = 1; val = a >> b[4:0]; end
            OP_SRA:    begin wr = 1; val = $signed(a) >>> b[4:0]; end
            OP_OR:     begin wr = 1; val = a | b; end
            OP_AND:    begin wr = 1; val = a & b; end
            OP_MUL:    begin wr = 1; val = a * b; end
            OP_MULH: begin
               wr = 1;
               prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
               val = prod[63:32];
            end
            OP_MULHSU: begin
               wr = 1;
               prod = {{32{a[31]}}, a} * {32'd0, b};
               val = prod[63:32];
            end
            OP_MULHU: begin
               wr = 1;
               prod = {32'd0, a} * {32'd0, b};
               val = prod[63:32];
            end
            OP_DIV: begin
               wr = 1;
               if (b == 0) val = '1;
               else if (a == 32'h8000_0000 && b == '1) val = a;
               else val = $signed(a) / $signed(b);
            end
            OP_DIVU:   begin wr = 1; val = (b == 0) ? '1 : a / b; end
            OP_REM: begin
               wr = 1;
               if (b == 0) val = a;
               else if (a == 32'h8000_0000 && b == '1) val = '0;
               else val = $signed(a) % $signed(b);
            end
            OP_REMU:   begin wr = 1; val = (b == 0) ? a : a % b; end
            OP_ROT:    begin wr = 1; val = {a[7:0], a[15:8], a[23:16], a[31:24]}; end
            OP_IN: begin
               if (pending) flt = FAULT_CONTEST;
               else begin wr = 1; val = {regs[r.dest_reg][31:8], r.in_byte}; end
            end
            OP_OUT: begin
               ob = a[7:0];
               // first contest byte is swallowed
               if (pending && ob == CONTEST_BYTE) begin pending = 0; ob = '0; end
               else ov = 1;
            end
            default: begin flt = FAULT_BAD_OP; npc = pc; end
         endcase
         if (wr && r.dest_reg != 0) regs[r.dest_reg] = val;
         else begin wr = 0; val = '0; end
         pc = npc;
         res.next_pc = npc;
         res.reg_write = wr;
         res.write_index = wr ? r.dest_reg : 5'd0;
         res.write_value = val;
         res.out_valid = ov;
         res.out_byte = ob;
         res.fault = flt;
         pending_results.push_back(res);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h want %h", what, got, want);
         errors++;
      endtask

      task check(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            report("unexpected response", got.next_pc, '0);
            return;
         end
         want = pending_results.pop_front();
         if (got.next_pc !== want.next_pc) report("next_pc", got.next_pc, want.next_pc);
         if (got.reg_write !== want.reg_write)
            report("reg_write", got.reg_write, want.reg_write);
         if (got.write_index !== want.write_index)
            report("write_index", got.write_index, want.write_index);
         if (got.write_value !== want.write_value)
            report("write_value", got.write_value, want.write_value);
         if (got.out_valid !== want.out_valid)
            report("out_valid", got.out_valid, want.out_valid);
         if (got.out_byte !== want.out_byte) report("out_byte", got.out_byte, want.out_byte);
         if (got.fault !== want.fault) report("fault", got.fault, want.fault);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;

   rie_chan_if #(.payload_type(instr_type))  req ();
   rie_chan_if #(.payload_type(result_type)) rsp ();
   rie_chan_if #(.payload_type(csr_type))    csr ();

   exec_scoreboard sb = new();
   int sender_idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;

   always #5 clock = ~clock;

   risc_instruction_execute dut (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .req_op(req.payload.op), .req_dest_reg(req.payload.dest_reg),
      .req_src_a(req.payload.src_a), .req_src_b(req.payload.src_b),
      .req_immediate(req.payload.immediate), .req_in_byte(req.payload.in_byte),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_next_pc(rsp.payload.next_pc), .rsp_reg_write(rsp.payload.reg_write),
      .rsp_write_index(rsp.payload.write_index),
      .rsp_write_value(rsp.payload.write_value),
      .rsp_out_valid(rsp.payload.out_valid), .rsp_out_byte(rsp.payload.out_byte),
      .rsp_fault(rsp.payload.fault),
      .csr_valid(csr.valid), .csr_ready(csr.ready),
      .csr_index(csr.payload.index), .csr_data(csr.payload.data)
   );

   // receiver: random stalls plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) sb.check(rsp.payload);
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // valid stays up after a transfer so back-to-back items need one assignment
   task send_instr(instr_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= r;
      forever begin
         @(posedge clock);
         if (req.ready) break;
      end
      sb.note(r);
   endtask

   task req_idle();
      req.valid <= 1'b0;
   endtask

   task send_op(op_type op, logic [4:0] rd, logic [4:0] ra, logic [4:0] rb,
                logic [31:0] imm, logic [7:0] ib);
      instr_type r;
      r = '{op: op, dest_reg: rd, src_a: ra, src_b: rb, immediate: imm, in_byte: ib};
      send_instr(r);
   endtask

   task write_csr(logic [0:0] index, logic [2:0] data);
      csr.valid <= 1'b1;
      csr.payload <= '{index: index, data: data};
      forever begin
         @(posedge clock);
         if (csr.ready) break;
      end
      sb.configure(index, data);
   endtask

   task drain();
      req_idle();
      while (sb.pending_results.size() > 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   function logic [31:0] pick_imm();
      case ($urandom_range(7))
         0: return 32'h0;
         1: return 32'hffff_ffff;
         2: return 32'h8000_0000;
         3: return 32'h7fff_ffff;
         4: return $urandom_range(63);
         5: return 32'd0 - $urandom_range(63);
         default: return $urandom;
      endcase
   endfunction

   function instr_type random_instr();
      instr_type r;
      int unsigned n;
      r.op = $urandom_range(OP_OUT);
      r.dest_reg = $urandom;
      r.src_a = $urandom;
      r.src_b = $urandom;
      r.immediate = pick_imm();
      r.in_byte = $urandom;
      n = $urandom_range(99);
      if (n < 4) r.op = $urandom_range(63, 48);
      else if (n < 10) begin
         r.op = OP_LUI;
         if ($urandom_range(1)) r.immediate = {24'd0, CONTEST_BYTE};
      end else if (n < 14) r.op = OP_OUT;
      else if (n < 18) r.op = OP_IN;
      if (r.op inside {[OP_LB:OP_LHU]}) begin
         // loads only touch words already stored
         if (sb.stored_words.size() == 0) r.op = OP_SW;
         else begin
            n = sb.stored_words[$urandom_range(sb.stored_words.size() - 1)];
            r.immediate = n - sb.regs[r.src_a] + ($urandom << 16);
         end
      end
      return r;
   endfunction

   task contest_prelude();
      send_op(OP_ADDI, 5'd4, 5'd0, 5'd0, {24'd0, CONTEST_BYTE}, 8'h00);
      send_op(OP_IN, 5'd5, 5'd0, 5'd0, 32'h0, 8'h5a);
      send_op(OP_OUT, 5'd0, 5'd4, 5'd0, 32'h0, 8'h00);
      send_op(OP_OUT, 5'd0, 5'd4, 5'd0, 32'h0, 8'h00);
      send_op(OP_IN, 5'd5, 5'd0, 5'd0, 32'h0, 8'ha5);
   endtask

   task directed();
      send_op(OP_LUI, 5'd1, 5'd0, 5'd0, 32'h8000_0000, 8'h00);
      send_op(OP_LUI, 5'd2, 5'd0, 5'd0, 32'hffff_ffff, 8'h00);
      send_op(OP_LUI, 5'd3, 5'd0, 5'd0, 32'h7fff_ffff, 8'h00);
      send_op(OP_LUI, 5'd0, 5'd0, 5'd0, 32'h1234_5678, 8'h00);
      send_op(OP_SW, 5'd0, 5'd0, 5'd2, 32'd5, 8'h00);
      send_op(OP_LB, 5'd6, 5'd0, 5'd0, 32'd5, 8'h00);
      send_op(OP_LHU, 5'd6, 5'd0, 5'd0, 32'h0001_0005, 8'h00);
      send_op(OP_SH, 5'd0, 5'd1, 5'd2, 32'h8000_0006, 8'h00);
      send_op(OP_LH, 5'd7, 5'd0, 5'd0, 32'd6, 8'h00);
      send_op(OP_SB, 5'd0, 5'd0, 5'd2, 32'd7, 8'h00);
      send_op(OP_LBU, 5'd7, 5'd0, 5'd0, 32'd7, 8'h00);
      send_op(OP_LW, 5'd8, 5'd0, 5'd0, 32'd5, 8'h00);
      send_op(OP_DIV, 5'd9, 5'd1, 5'd2, 32'h0, 8'h00);
      send_op(OP_REM, 5'd9, 5'd1, 5'd2, 32'h0, 8'h00);
      send_op(OP_DIVU, 5'd9, 5'd3, 5'd0, 32'h0, 8'h00);
      send_op(OP_REMU, 5'd9, 5'd3, 5'd0, 32'h0, 8'h00);
      send_op(OP_MULH, 5'd10, 5'd1, 5'd1, 32'h0, 8'h00);
      send_op(OP_MULHSU, 5'd10, 5'd2, 5'd2, 32'h0, 8'h00);
      send_op(OP_MULHU, 5'd10, 5'd2, 5'd2, 32'h0, 8'h00);
      send_op(OP_ROT, 5'd11, 5'd3, 5'd0, 32'h0, 8'h00);
      send_op(OP_SRAI, 5'd12, 5'd1, 5'd0, 32'hffff_ffff, 8'h00);
      send_op(OP_JALR, 5'd13, 5'd2, 5'd0, 32'd3, 8'h00);
      send_op(OP_AUIPC, 5'd14, 5'd0, 5'd0, 32'h8000_0000, 8'h00);
      send_op(op_type'(6'd63), 5'd15, 5'd1, 5'd2, 32'hffff_ffff, 8'hff);
   endtask

   initial begin
      logic [2:0] step_list [6] = '{3'd4, 3'd1, 3'd7, 3'd0, 3'd3, 3'd2};
      instr_type r;
      req.valid = 1'b0;
      req.payload = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.payload = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed();
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_csr(CSR_PC_STEP, step_list[ph]);
         write_csr(CSR_CONTEST_MODE, ph[0]);
         csr.valid <= 1'b0;
         case (ph % 4)
            0: begin sender_idle_pct = 0; stall_pct = 0; end
            1: begin sender_idle_pct = 58; stall_pct = 0; end
            2: begin sender_idle_pct = 0; stall_pct = 58; end
            default: begin sender_idle_pct = 14; stall_pct = 14; end
         endcase
         contest_prelude();
         for (int i = 0; i < 285; i++) begin
            if (i == 100 && ph == 0) hold_cycles = 300;
            if (i == 150) begin
               // let the block run empty mid-phase
               req_idle();
               while (sb.pending_results.size() > 0) @(posedge clock);
            end
            r = random_instr();
            send_instr(r);
         end
      end
      req_idle();
      while (sb.pending_results.size() > 0) @(posedge clock);
      repeat (45) @(posedge clock);
      if (sb.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
